// ===== src/sle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, character codes and the report text of the line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LINE_CAPACITY_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_DEL = 8'h7F;

  // Fixed bytes at the head of a line report: CR LF and "Received: ".
  localparam int HEAD_LEN = 12;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ERASE  = 2'd1,
    OP_LINE   = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] head_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CHAR_CR;
      4'd1:    c = CHAR_LF;
      4'd2:    c = 8'h52; // R
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h63; // c
      4'd5:    c = 8'h65; // e
      4'd6:    c = 8'h69; // i
      4'd7:    c = 8'h76; // v
      4'd8:    c = 8'h65; // e
      4'd9:    c = 8'h64; // d
      4'd10:   c = 8'h3A; // :
      4'd11:   c = CHAR_SP;
      default: c = CHAR_SP;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/sle_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_front
// Accept received bytes, classify them and hand commands to the queue.
// ----------------------------------------------------------------------------
module sle_front (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output sle_pkg::cmd_t      q_cmd
);

  logic keep;

  always_comb begin
    keep        = 1'b1;
    q_cmd.data  = in_rx_byte;
    q_cmd.op    = sle_pkg::OP_APPEND;
    if (in_rx_byte == sle_pkg::CHAR_CR || in_rx_byte == sle_pkg::CHAR_LF) begin
      q_cmd.op = sle_pkg::OP_LINE;
    end else if (in_rx_byte == sle_pkg::CHAR_BS || in_rx_byte == sle_pkg::CHAR_DEL) begin
      q_cmd.op = sle_pkg::OP_ERASE;
    end else if (in_rx_byte >= sle_pkg::CHAR_SP && in_rx_byte < sle_pkg::CHAR_DEL) begin
      q_cmd.op = sle_pkg::OP_APPEND;
    end else begin
      // drop other control bytes and high bytes
      keep = 1'b0;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule
`default_nettype wire

// ===== src/sle_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_queue
// Short command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module sle_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sle_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output sle_pkg::cmd_t      head_cmd
);

  localparam int DEPTH = sle_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sle_pkg::cmd_t          slot_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== src/sle_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_back
// Execute commands: keep the line store and fill count, emit reply bytes.
// ----------------------------------------------------------------------------
module sle_back #(
  parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire sle_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_tx_byte,
  output logic               out_last,
  output logic               out_led_toggle
);

  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int POS_W  = $clog2(sle_pkg::HEAD_LEN + 2 + LINE_CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [7:0]        mem [LINE_CAPACITY];
  logic [7:0]        mem_q;

  logic              state_r, state_nxt;
  sle_pkg::op_t      op_r, op_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r, out_led_r;

  logic              load;
  logic              wr_en;
  logic [7:0]        byte_sel;
  logic              last_sel, led_sel, store_sel;
  logic [POS_W-1:0]  fill_ext;

  assign fill_ext = POS_W'(fill_r);
  assign load     = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    byte_sel  = ch_r;
    last_sel  = 1'b0;
    led_sel   = 1'b0;
    store_sel = 1'b0;
    case (op_r)
      sle_pkg::OP_APPEND: begin
        byte_sel = ch_r;
        last_sel = 1'b1;
      end
      sle_pkg::OP_ERASE: begin
        byte_sel = (pos_r == POS_W'(1)) ? sle_pkg::CHAR_SP : sle_pkg::CHAR_BS;
        last_sel = (pos_r == POS_W'(2));
      end
      sle_pkg::OP_LINE: begin
        if (pos_r < POS_W'(sle_pkg::HEAD_LEN)) begin
          byte_sel = sle_pkg::head_char(pos_r[3:0]);
        end else if (pos_r < POS_W'(sle_pkg::HEAD_LEN) + fill_ext) begin
          byte_sel  = mem_q;
          store_sel = 1'b1;
        end else if (pos_r == POS_W'(sle_pkg::HEAD_LEN) + fill_ext) begin
          byte_sel = sle_pkg::CHAR_CR;
        end else begin
          byte_sel = sle_pkg::CHAR_LF;
          last_sel = 1'b1;
          led_sel  = 1'b1;
        end
      end
      default: begin
        byte_sel = ch_r;
        last_sel = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ch_nxt     = ch_r;
    pos_nxt    = pos_r;
    fill_nxt   = fill_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_en      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          op_nxt  = q_cmd.op;
          ch_nxt  = q_cmd.data;
          pos_nxt = '0;
          case (q_cmd.op)
            sle_pkg::OP_APPEND: begin
              // drop the byte when the line already holds LINE_CAPACITY - 1 bytes
              if (fill_r < ADDR_W'(LINE_CAPACITY - 1)) begin
                wr_en     = 1'b1;
                fill_nxt  = fill_r + 1'b1;
                state_nxt = ST_RUN;
              end
            end
            sle_pkg::OP_ERASE: begin
              if (fill_r != '0) begin
                fill_nxt  = fill_r - 1'b1;
                state_nxt = ST_RUN;
              end
            end
            sle_pkg::OP_LINE: begin
              state_nxt = ST_RUN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (load) begin
          pos_nxt = pos_r + 1'b1;
          if (store_sel) begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end
          if (last_sel) begin
            state_nxt = ST_IDLE;
            if (op_r == sle_pkg::OP_LINE) begin
              fill_nxt   = '0;
              rd_ptr_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (state_r == ST_RUN && load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    ch_r  <= ch_nxt;
    pos_r <= pos_nxt;
    if (state_r == ST_RUN && load) begin
      out_byte_r <= byte_sel;
      out_last_r <= last_sel;
      out_led_r  <= led_sel;
    end
  end

  // Line store: one write port, one registered read port that prefetches.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r] <= q_cmd.data;
    end
    mem_q <= mem[rd_ptr_nxt];
  end

  assign out_valid      = out_valid_r;
  assign out_tx_byte    = out_byte_r;
  assign out_last       = out_last_r;
  assign out_led_toggle = out_led_r;

endmodule
`default_nettype wire

// ===== src/serial_line_editor_echo_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_editor_echo_core
// Serial console line editor with echo, erase and completed-line report.
// ----------------------------------------------------------------------------
// Path: an accepted byte passes the queue slot, the sequencer's command registers
//   and the output registers before its first reply byte shows on out_*.
// Replies: set by the reply sequencer, a run goes out at one byte per cycle while
//   out_stall is low, once the sequencer has taken its command from the queue.
// Reset: synchronous, active low; clears the fill count, the queue and the
//   output valid. The line store is not cleared and is read only where written.
// ----------------------------------------------------------------------------
module serial_line_editor_echo_core #(
  parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_tx_byte,
  output logic            out_last,
  output logic            out_led_toggle
);

  // Front to queue.
  logic          q_push;
  sle_pkg::cmd_t q_push_cmd;
  logic          q_full;
  // Queue to back.
  logic          q_pop;
  logic          q_empty;
  sle_pkg::cmd_t q_head_cmd;

  // Classify each item; ignored bytes are accepted and dropped here.
  sle_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd)
  );

  // Hold commands while the sequencer is busy with a reply.
  sle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head_cmd)
  );

  // Update the line and advance through the reply bytes, one per cycle while out_stall is low.
  sle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_head_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .out_led_toggle (out_led_toggle)
  );

endmodule
`default_nettype wire
